// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL of the collision depth block.
// Each use expands to one labeled concurrent assertion clocked on clk, held off by rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== src/cbcd_pkg.sv =====
// Shared widths, command codes and pipeline types for the collision depth block.
// No dependencies; cbcd_front, cbcd_cell and the top module import this package.
package cbcd_pkg;

  localparam int COORD_BITS = 24;
  localparam int SIZE_BITS  = COORD_BITS - 1;
  localparam int WIDE_BITS  = COORD_BITS + 2;      // room for edge sums and differences
  localparam int MAG_BITS   = COORD_BITS + 1;      // distances, overlaps, depth
  localparam int LIM_BITS   = COORD_BITS;          // summed radii
  localparam int SQ_BITS    = 2 * MAG_BITS;        // sum of squares
  localparam int REM_BITS   = MAG_BITS + 2;        // square root remainder
  localparam int NCELLS     = MAG_BITS;            // one root bit per cell

  localparam int IN_BITS       = 4 * COORD_BITS + 4 * SIZE_BITS;
  localparam int IN_TDATA_BITS = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_BITS = ((MAG_BITS + 7) / 8) * 8;

  // tdata field offsets, lowest first
  localparam int OFF_AX = 0;
  localparam int OFF_AY = OFF_AX + COORD_BITS;
  localparam int OFF_AW = OFF_AY + COORD_BITS;
  localparam int OFF_AH = OFF_AW + SIZE_BITS;
  localparam int OFF_BX = OFF_AH + SIZE_BITS;
  localparam int OFF_BY = OFF_BX + COORD_BITS;
  localparam int OFF_BW = OFF_BY + COORD_BITS;
  localparam int OFF_BH = OFF_BW + SIZE_BITS;

  typedef enum logic [1:0] {
    CMD_CIRCLE = 2'd0,
    CMD_BOX    = 2'd1,
    CMD_CBOX   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  // what rides along with the root
  typedef struct packed {
    logic                kill;   // no overlap, depth is zero
    logic                box;    // depth is the root itself
    logic [LIM_BITS-1:0] lim;    // depth is lim minus root
  } tag_t;

  // data handed from cell to cell
  typedef struct packed {
    logic [REM_BITS-1:0] rem;
    logic [MAG_BITS-1:0] root;
    logic [SQ_BITS-1:0]  rad;
    tag_t                tag;
  } cell_t;

endpackage

// ===== src/cbcd_front.sv =====
// Front end: decodes the shape pair, squares the distances and forms the radicand.
// Depends on cbcd_pkg. Three registered stages with their own handshake.
module cbcd_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 up_ready,
  input  cbcd_pkg::cmd_t                       cmd,
  input  logic signed [cbcd_pkg::COORD_BITS-1:0] ax,
  input  logic signed [cbcd_pkg::COORD_BITS-1:0] ay,
  input  logic [cbcd_pkg::SIZE_BITS-1:0]       aw,
  input  logic [cbcd_pkg::SIZE_BITS-1:0]       ah,
  input  logic signed [cbcd_pkg::COORD_BITS-1:0] bx,
  input  logic signed [cbcd_pkg::COORD_BITS-1:0] by,
  input  logic [cbcd_pkg::SIZE_BITS-1:0]       bw,
  input  logic [cbcd_pkg::SIZE_BITS-1:0]       bh,
  input  logic                                 dn_ready,
  output logic                                 out_valid,
  output cbcd_pkg::cell_t                      dout
);
  import cbcd_pkg::*;

  logic signed [WIDE_BITS-1:0] wax, way, wbx, wby, war, wab, wbr, wbb;
  logic signed [WIDE_BITS-1:0] p1, p2, q1, q2, xp, yp, px, py, dx, dy, adx, ady;
  logic                        overlap;
  logic [LIM_BITS-1:0]         lim_c;
  logic [MAG_BITS-1:0]         ux_c, uy_c;
  tag_t                        tag_c;

  logic                v1, v2, v3;
  logic                r1, r2, r3;
  logic [MAG_BITS-1:0] ux1, uy1;
  tag_t                tag1, tag2, tag3;
  tag_t                tag2k;
  logic [SQ_BITS-1:0]  s2, t2, rad3;
  logic [2*LIM_BITS-1:0] l2;

  // stage handshake, bubbles collapse
  assign r3       = !v3 || dn_ready;
  assign r2       = !v2 || r3;
  assign r1       = !v1 || r2;
  assign up_ready = r1;

  // edges of both shapes
  always_comb begin
    wax = WIDE_BITS'(ax);
    way = WIDE_BITS'(ay);
    wbx = WIDE_BITS'(bx);
    wby = WIDE_BITS'(by);
    war = wax + $signed({2'b00, {(WIDE_BITS-2-SIZE_BITS){1'b0}}, aw});
    wab = way + $signed({2'b00, {(WIDE_BITS-2-SIZE_BITS){1'b0}}, ah});
    wbr = wbx + $signed({2'b00, {(WIDE_BITS-2-SIZE_BITS){1'b0}}, bw});
    wbb = wby + $signed({2'b00, {(WIDE_BITS-2-SIZE_BITS){1'b0}}, bh});
    overlap = (wax < wbr) && (war > wbx) && (way < wbb) && (wab > wby);
    p1 = wbr - wax;
    p2 = war - wbx;
    q1 = wbb - way;
    q2 = wab - wby;
    xp = (p1 < p2) ? p1 : p2;
    yp = (q1 < q2) ? q1 : q2;
    // clamp circle center into box b
    if (wax > wbr) begin
      px = wbr;
    end else if (wax < wbx) begin
      px = wbx;
    end else begin
      px = wax;
    end
    if (way > wbb) begin
      py = wbb;
    end else if (way < wby) begin
      py = wby;
    end else begin
      py = way;
    end
  end

  // per-command offsets, limit and early reject
  always_comb begin
    dx    = wax - wbx;
    dy    = way - wby;
    lim_c = LIM_BITS'(aw) + LIM_BITS'(bw);
    tag_c = '0;
    case (cmd)
      CMD_CIRCLE: begin
        dx    = wax - wbx;
        dy    = way - wby;
        lim_c = LIM_BITS'(aw) + LIM_BITS'(bw);
      end
      CMD_CBOX: begin
        dx    = wax - px;
        dy    = way - py;
        lim_c = LIM_BITS'(aw);
      end
      CMD_BOX: begin
        dx = xp;
        dy = yp;
      end
      default: begin
        dx = '0;
        dy = '0;
      end
    endcase
    adx  = (dx < 0) ? -dx : dx;
    ady  = (dy < 0) ? -dy : dy;
    ux_c = adx[MAG_BITS-1:0];
    uy_c = ady[MAG_BITS-1:0];
    tag_c.lim = lim_c;
    tag_c.box = (cmd == CMD_BOX);
    case (cmd)
      CMD_CIRCLE, CMD_CBOX:
        tag_c.kill = (lim_c == '0) || (ux_c >= MAG_BITS'(lim_c)) || (uy_c >= MAG_BITS'(lim_c));
      CMD_BOX:  tag_c.kill = !overlap;
      default:  tag_c.kill = 1'b1;
    endcase
  end

  // reject once the squared distance reaches the squared limit
  always_comb begin
    tag2k      = tag2;
    tag2k.kill = tag2.kill || (!tag2.box && (t2 >= SQ_BITS'(l2) - s2));
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
    end
  end

  // stage payloads: decode, square, radicand
  always_ff @(posedge clk) begin
    if (r1) begin
      ux1  <= ux_c;
      uy1  <= uy_c;
      tag1 <= tag_c;
    end
    if (r2) begin
      s2   <= ux1 * ux1;
      t2   <= uy1 * uy1;
      l2   <= tag1.lim * tag1.lim;
      tag2 <= tag1;
    end
    if (r3) begin
      rad3 <= s2 + t2;
      tag3 <= tag2k;
    end
  end

  assign out_valid = v3;
  always_comb begin
    dout      = '0;
    dout.rad  = rad3;
    dout.tag  = tag3;
  end

endmodule

// ===== src/cbcd_cell.sv =====
// One square root cell: settles one root bit from the next two radicand bits.
// Depends on cbcd_pkg. Cells are chained, each a pipeline stage.
module cbcd_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            up_ready,
  input  cbcd_pkg::cell_t din,
  input  logic            dn_ready,
  output logic            out_valid,
  output cbcd_pkg::cell_t dout
);
  import cbcd_pkg::*;

  logic [REM_BITS+1:0] window;
  logic [REM_BITS-1:0] trial;
  logic                take;
  logic [REM_BITS+1:0] diff;
  cell_t               nxt;

  assign up_ready = !out_valid || dn_ready;

  // shift in two bits, try root*4+1
  always_comb begin
    window = {din.rem, din.rad[SQ_BITS-1 -: 2]};
    trial  = {din.root, 2'b01};
    take   = window >= (REM_BITS+2)'(trial);
    diff   = window - (REM_BITS+2)'(trial);
    nxt     = din;
    nxt.rad = {din.rad[SQ_BITS-3:0], 2'b00};
    if (take) begin
      nxt.rem  = diff[REM_BITS-1:0];
      nxt.root = {din.root[MAG_BITS-2:0], 1'b1};
    end else begin
      nxt.rem  = window[REM_BITS-1:0];
      nxt.root = {din.root[MAG_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (up_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      dout <= nxt;
    end
  end

endmodule

// ===== src/circle_box_collision_depth.sv =====
// Collision depth of a circle or box pair: front end, square root cell chain, output register.
// Depends on cbcd_pkg, cbcd_front, cbcd_cell and assert_macros.svh.
//
// Use: one shape pair per beat on the s_ channel, command on s_tuser, shape fields on s_tdata.
// Command circle-circle gives summed radii minus center distance, box-box gives the
// hypotenuse of the smaller x and y overlaps, circle-box clamps the circle center into
// box b and gives radius minus distance. Touching or separated shapes give depth 0.
// The unused command gives depth 0. Results leave on the m_ channel, depth on m_tdata,
// hit flag on m_tuser, in input order, one per input beat.
// From input beat to m_tvalid: three front stages, 25 root cells, one output
// register. Throughput: one beat per cycle while m_tready stays high, set by the root
// chain, one root bit per cell, every stage registered.
// Every stage holds its own beat; when m_tready is low the output register holds and
// stages behind it keep filling empty slots, so s_tready stays high while bubbles remain
// and drops only once the whole chain is full.
// Reset (rst, synchronous, active high) empties every stage; s_tready is high after it.
module circle_box_collision_depth (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     s_tvalid,
  output logic                                     s_tready,
  // a_x, a_y, a_size, a_height, b_x, b_y, b_size, b_height, zero pad
  input  logic [cbcd_pkg::IN_TDATA_BITS-1:0]       s_tdata,
  // command
  input  logic [1:0]                               s_tuser,
  output logic                                     m_tvalid,
  input  logic                                     m_tready,
  // depth, zero pad
  output logic [cbcd_pkg::OUT_TDATA_BITS-1:0]      m_tdata,
  // hit
  output logic [0:0]                               m_tuser
);
  import cbcd_pkg::*;
  `include "assert_macros.svh"

  cell_t             chain [0:NCELLS];
  logic [NCELLS:0]   cvalid;
  logic [NCELLS:0]   cready;
  logic              out_ready;
  logic [MAG_BITS-1:0] depth_next;
  logic [MAG_BITS-1:0] depth;
  cmd_t              cmd;

  assign cmd = cmd_t'(s_tuser);

  cbcd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .up_ready (s_tready),
    .cmd      (cmd),
    .ax       ($signed(s_tdata[OFF_AX +: COORD_BITS])),
    .ay       ($signed(s_tdata[OFF_AY +: COORD_BITS])),
    .aw       (s_tdata[OFF_AW +: SIZE_BITS]),
    .ah       (s_tdata[OFF_AH +: SIZE_BITS]),
    .bx       ($signed(s_tdata[OFF_BX +: COORD_BITS])),
    .by       ($signed(s_tdata[OFF_BY +: COORD_BITS])),
    .bw       (s_tdata[OFF_BW +: SIZE_BITS]),
    .bh       (s_tdata[OFF_BH +: SIZE_BITS]),
    .dn_ready (cready[0]),
    .out_valid(cvalid[0]),
    .dout     (chain[0])
  );

  // root chain, one bit per cell, most significant first
  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    cbcd_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (cvalid[i]),
      .up_ready (cready[i]),
      .din      (chain[i]),
      .dn_ready (cready[i+1]),
      .out_valid(cvalid[i+1]),
      .dout     (chain[i+1])
    );
  end

  // output register
  assign out_ready      = !m_tvalid || m_tready;
  assign cready[NCELLS] = out_ready;

  always_comb begin
    if (chain[NCELLS].tag.kill) begin
      depth_next = '0;
    end else if (chain[NCELLS].tag.box) begin
      depth_next = chain[NCELLS].root;
    end else begin
      depth_next = MAG_BITS'(chain[NCELLS].tag.lim) - chain[NCELLS].root;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_tvalid <= cvalid[NCELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready) begin
      depth <= depth_next;
    end
  end

  assign m_tdata    = OUT_TDATA_BITS'(depth);
  assign m_tuser[0] = (depth != '0);

  // checks
  `ASSERT_IMP(a_hit_matches_depth, m_tvalid, m_tuser[0] == (m_tdata[MAG_BITS-1:0] != '0))
  `ASSERT_IMP(a_ready_when_empty, !m_tvalid, s_tready)
  `ASSERT_NXT(a_drain_no_ghost, m_tvalid && m_tready && !cvalid[NCELLS], !m_tvalid)

endmodule
